>>> rtl/fdtd_2d_tm_quadrant_step_defines.svh
// Assertion macros for the design file that checks itself.
`ifndef FDTD_2D_TM_QUADRANT_STEP_DEFINES_SVH
`define FDTD_2D_TM_QUADRANT_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FDTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdtd check failed");
`define FDTD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdtd check failed");
`else
`define FDTD_ASSERT_IMP(label, clk, rst, ante, cons)
`define FDTD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/fdtd_pkg.sv
package fdtd_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 6;
   localparam int CSR_AW = 5;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_STEP = 2'd2;

   localparam logic [3:0] GRID_EZ = 4'd0;
   localparam logic [3:0] GRID_EZ_A = 4'd3;
   localparam logic [3:0] NUM_GRIDS = 4'd9;

   localparam logic [1:0] LANE_EZ = 2'd0;
   localparam logic [1:0] LANE_HX = 2'd1;
   localparam logic [1:0] LANE_HY = 2'd2;

   localparam logic [2:0] COEF_EZ_A = 3'd0;
   localparam logic [2:0] COEF_EZ_B = 3'd1;
   localparam logic [2:0] COEF_HX_A = 3'd2;
   localparam logic [2:0] COEF_HX_B = 3'd3;
   localparam logic [2:0] COEF_HY_A = 3'd4;
   localparam logic [2:0] COEF_HY_B = 3'd5;

   localparam logic [2:0] REG_ROWS = 3'd0;
   localparam logic [2:0] REG_COLS = 3'd1;
   localparam logic [2:0] REG_EXR = 3'd2;
   localparam logic [2:0] REG_EXC = 3'd3;
   localparam logic [2:0] REG_GAIN = 3'd4;

   typedef logic signed [31:0] word_type;
   typedef logic [2:0][31:0] fld_type;
   typedef logic [5:0][31:0] coef_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_EXEC, ST_RDATA, ST_RD, ST_RD2, ST_CAP, ST_MUL,
      ST_WR, ST_MWR, ST_FIN, ST_RESP
   } st_type;

   typedef enum logic [3:0] {
      PH_EZ, PH_SRC, PH_EZ_MC, PH_EZ_MR, PH_HX, PH_HX_MC, PH_HX_MR,
      PH_HY, PH_HY_MR, PH_HY_MC, PH_FIN
   } phase_type;

   function automatic word_type sat32(input logic signed [63:0] v);
      word_type r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic word_type dif32(input word_type a, input word_type b);
      logic signed [32:0] d;
      word_type r;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         r = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = d[31:0];
      end
      return r;
   endfunction

   function automatic word_type neg32(input word_type v);
      word_type r;
      if (v == 32'sh8000_0000) begin
         r = 32'sh7FFF_FFFF;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

>>> rtl/fdtd_2d_tm_quadrant_step.sv
// Two-dimensional TM field solver holding Ez, Hx, Hy and six coefficient grids in
// two single-port-write memories (field words and coefficient words, one cell per
// entry). A step walks the grids one cell at a time: an updated cell has its products
// formed in turn by one shared multiplier, and a mirrored cell is read, then written.
// After reset a clearing pass over all MAX_ROWS by MAX_COLS (rounded up to powers
// of two) entries zeroes the field memory before the first word is accepted.
`include "fdtd_2d_tm_quadrant_step_defines.svh"

module fdtd_2d_tm_quadrant_step
   import fdtd_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int FRAC_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // row[5:0], col[11:6], word[43:12]
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // action[1:0], grid_sel[5:2]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // data[31:0]
   output logic [0:0]             rsp_tuser,   // status[0]
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int RDW = $clog2(MAX_ROWS + 1);
   localparam int CDW = $clog2(MAX_COLS + 1);
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic [6:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [5:0] exr_ff, exr_in, exc_ff, exc_in;
   word_type gain_ff, gain_in;

   st_type st_ff, st_in;
   phase_type phase_ff, phase_in, ph_nx;
   logic [RW-1:0] y_ff, y_in;
   logic [CW-1:0] x_ff, x_in;
   logic [1:0] k_ff, k_in, klast;
   logic [AW-1:0] clr_ff, clr_in;

   logic [1:0] act_ff, act_in;
   logic [3:0] sel_ff, sel_in;
   logic [5:0] row_ff, row_in, col_ff, col_in;
   word_type word_ff, word_in;

   fld_type own_ff, own_in, nb_ff, nb_in;
   word_type ca_ff, ca_in, cb_ff, cb_in, d1_ff, d1_in, d2_ff, d2_in;
   logic signed [63:0] acc_ff, acc_in, prod_ff, prod_in, term, acc_nxt;
   logic neg_ff, neg_in;
   word_type res_data_ff, res_data_in;
   logic res_stat_ff, res_stat_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_stat_ff, rsp_stat_in;
   word_type rsp_data_ff, rsp_data_in;

   fld_type fmem [DEPTH];
   coef_type cmem [DEPTH];
   fld_type fa_q, fb_q;
   coef_type c_q;
   logic [AW-1:0] fra, frb, waddr;
   logic [2:0] fwe;
   logic [5:0] cwe;
   word_type fwd;

   logic [RDW-1:0] dim_r, rm1;
   logic [CDW-1:0] dim_c, cm1;
   logic [RW-1:0] hy, r_m1, er_c, y1, ys, src_y;
   logic [CW-1:0] hx, c_m1, ec_c, x0, x1, xs, src_x;
   logic ex_ok, cell_ok, sel_ok, upd, wr_cfg;
   word_type mul_a, mul_b;
   logic mul_neg;
   logic [1:0] lane;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign wr_cfg = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      exr_in = exr_ff;
      exc_in = exc_ff;
      gain_in = gain_ff;
      if (wr_cfg) begin
         unique case (csr_paddr[4:2])
            REG_ROWS: rows_in = csr_pwdata[6:0];
            REG_COLS: cols_in = csr_pwdata[6:0];
            REG_EXR: exr_in = csr_pwdata[5:0];
            REG_EXC: exc_in = csr_pwdata[5:0];
            REG_GAIN: gain_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ROWS: csr_prdata = 32'(rows_ff);
         REG_COLS: csr_prdata = 32'(cols_ff);
         REG_EXR: csr_prdata = 32'(exr_ff);
         REG_EXC: csr_prdata = 32'(exc_ff);
         REG_GAIN: csr_prdata = gain_ff;
         default: csr_prdata = 32'd0;
      endcase
   end

   // Grid geometry.
   always_comb begin
      if (rows_ff < 7'd3) begin
         dim_r = RDW'(3);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         dim_r = RDW'(MAX_ROWS);
      end else begin
         dim_r = RDW'(rows_ff);
      end
      if (cols_ff < 7'd3) begin
         dim_c = CDW'(3);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         dim_c = CDW'(MAX_COLS);
      end else begin
         dim_c = CDW'(cols_ff);
      end
   end

   assign rm1 = dim_r - RDW'(1);
   assign cm1 = dim_c - CDW'(1);
   assign r_m1 = RW'(rm1);
   assign c_m1 = CW'(cm1);
   assign hy = RW'(rm1 >> 1);
   assign hx = CW'(cm1 >> 1);
   assign er_c = RW'(exr_ff);
   assign ec_c = CW'(exc_ff);
   assign ex_ok = (32'(exr_ff) < 32'(dim_r)) && (32'(exc_ff) < 32'(dim_c));
   assign cell_ok = (32'(row_ff) < 32'(dim_r)) && (32'(col_ff) < 32'(dim_c));
   assign sel_ok = sel_ff < NUM_GRIDS;
   assign upd = (phase_ff == PH_EZ) || (phase_ff == PH_SRC) || (phase_ff == PH_HX)
              || (phase_ff == PH_HY);

   // Scan bounds of the current pass.
   always_comb begin
      unique case (phase_ff)
         PH_EZ: begin y1 = hy; x0 = CW'(1); x1 = hx; end
         PH_EZ_MC: begin y1 = hy; x0 = hx + 1'b1; x1 = c_m1; end
         PH_EZ_MR: begin y1 = r_m1; x0 = CW'(1); x1 = c_m1; end
         PH_HX: begin y1 = hy - 1'b1; x0 = '0; x1 = hx; end
         PH_HX_MC: begin y1 = hy - 1'b1; x0 = hx + 1'b1; x1 = c_m1; end
         PH_HX_MR: begin y1 = r_m1 - 1'b1; x0 = CW'(1); x1 = c_m1; end
         PH_HY: begin y1 = hy; x0 = '0; x1 = hx - 1'b1; end
         PH_HY_MR: begin y1 = r_m1; x0 = '0; x1 = hx - 1'b1; end
         PH_HY_MC: begin y1 = r_m1; x0 = hx; x1 = c_m1 - 1'b1; end
         default: begin y1 = er_c; x0 = ec_c; x1 = ec_c; end
      endcase
   end

   // Following pass and its first cell.
   always_comb begin
      unique case (phase_ff)
         PH_EZ: ph_nx = ex_ok ? PH_SRC : PH_EZ_MC;
         PH_SRC: ph_nx = PH_EZ_MC;
         PH_EZ_MC: ph_nx = PH_EZ_MR;
         PH_EZ_MR: ph_nx = PH_HX;
         PH_HX: ph_nx = PH_HX_MC;
         PH_HX_MC: ph_nx = PH_HX_MR;
         PH_HX_MR: ph_nx = PH_HY;
         PH_HY: ph_nx = PH_HY_MR;
         PH_HY_MR: ph_nx = PH_HY_MC;
         default: ph_nx = PH_FIN;
      endcase
      unique case (ph_nx)
         PH_EZ: begin ys = RW'(1); xs = CW'(1); end
         PH_EZ_MC: begin ys = RW'(1); xs = hx + 1'b1; end
         PH_EZ_MR: begin ys = hy + 1'b1; xs = CW'(1); end
         PH_HX: begin ys = '0; xs = '0; end
         PH_HX_MC: begin ys = '0; xs = hx + 1'b1; end
         PH_HX_MR: begin ys = hy; xs = CW'(1); end
         PH_HY: begin ys = '0; xs = '0; end
         PH_HY_MR: begin ys = hy + 1'b1; xs = '0; end
         PH_HY_MC: begin ys = '0; xs = hx; end
         default: begin ys = er_c; xs = ec_c; end
      endcase
   end

   // Source cell of a mirror copy and the lane it moves.
   always_comb begin
      src_y = y_ff;
      src_x = x_ff;
      unique case (phase_ff)
         PH_EZ_MC, PH_HX_MC: src_x = CW'(cm1 - CDW'(x_ff));
         PH_EZ_MR, PH_HY_MR: src_y = RW'(rm1 - RDW'(y_ff));
         PH_HX_MR: src_y = RW'(rm1 - RDW'(y_ff) - RDW'(1));
         PH_HY_MC: src_x = CW'(cm1 - CDW'(x_ff) - CDW'(1));
         default: ;
      endcase
      unique case (phase_ff)
         PH_HX, PH_HX_MC, PH_HX_MR: lane = LANE_HX;
         PH_HY, PH_HY_MR, PH_HY_MC: lane = LANE_HY;
         default: lane = LANE_EZ;
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_EZ: klast = 2'd2;
         PH_SRC: klast = 2'd0;
         default: klast = 2'd1;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      st_in = st_ff;
      phase_in = phase_ff;
      y_in = y_ff;
      x_in = x_ff;
      k_in = k_ff;
      clr_in = clr_ff;
      unique case (st_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) st_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (act_ff)
               ACT_READ: st_in = (cell_ok && sel_ok) ? ST_RDATA : ST_RESP;
               ACT_STEP: begin
                  phase_in = PH_EZ;
                  y_in = RW'(1);
                  x_in = CW'(1);
                  st_in = ST_RD;
               end
               default: st_in = ST_RESP;
            endcase
         end
         ST_RDATA: st_in = ST_RESP;
         ST_RD: begin
            if (upd) begin
               st_in = ST_RD2;
            end else if (phase_ff == PH_FIN) begin
               st_in = ST_FIN;
            end else begin
               st_in = ST_MWR;
            end
         end
         ST_RD2: st_in = ST_CAP;
         ST_CAP: begin
            st_in = ST_MUL;
            k_in = 2'd0;
         end
         ST_MUL: begin
            if (k_ff == klast) begin
               st_in = ST_WR;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_WR, ST_MWR: begin
            st_in = ST_RD;
            if (x_ff == x1) begin
               if (y_ff == y1) begin
                  if (phase_ff == PH_HY_MC && !ex_ok) begin
                     st_in = ST_RESP;
                  end else begin
                     phase_in = ph_nx;
                     y_in = ys;
                     x_in = xs;
                  end
               end else begin
                  y_in = y_ff + 1'b1;
                  x_in = x0;
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_FIN: st_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // Multiplier operands.
   always_comb begin
      mul_a = cb_ff;
      mul_b = d1_ff;
      mul_neg = 1'b0;
      unique case (phase_ff)
         PH_EZ: begin
            if (k_ff == 2'd0) begin
               mul_a = ca_ff;
               mul_b = own_ff[LANE_EZ];
            end else if (k_ff == 2'd2) begin
               mul_b = d2_ff;
               mul_neg = 1'b1;
            end
         end
         PH_HX: begin
            if (k_ff == 2'd0) begin
               mul_a = ca_ff;
               mul_b = own_ff[LANE_HX];
            end else begin
               mul_neg = 1'b1;
            end
         end
         PH_HY: begin
            if (k_ff == 2'd0) begin
               mul_a = ca_ff;
               mul_b = own_ff[LANE_HY];
            end
         end
         default: begin
            mul_a = gain_ff;
            mul_b = word_ff;
            mul_neg = 1'b1;
         end
      endcase
   end

   assign term = (prod_ff + HALF) >>> FRAC_BITS;
   assign acc_nxt = neg_ff ? (acc_ff - term) : (acc_ff + term);

   // Memory ports, datapath and result.
   always_comb begin
      act_in = act_ff;
      sel_in = sel_ff;
      row_in = row_ff;
      col_in = col_ff;
      word_in = word_ff;
      own_in = own_ff;
      nb_in = nb_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      d1_in = d1_ff;
      d2_in = d2_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      neg_in = neg_ff;
      res_data_in = res_data_ff;
      res_stat_in = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_stat_in = rsp_stat_ff;
      fra = {y_ff, x_ff};
      frb = {y_ff, x_ff};
      waddr = {y_ff, x_ff};
      fwe = 3'd0;
      cwe = 6'd0;
      fwd = word_ff;
      req_tready = 1'b0;
      unique case (st_ff)
         ST_CLR: begin
            waddr = clr_ff;
            fwe = 3'b111;
            fwd = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            act_in = req_tuser[1:0];
            sel_in = req_tuser[5:2];
            row_in = req_tdata[5:0];
            col_in = req_tdata[11:6];
            word_in = req_tdata[43:12];
         end
         ST_EXEC: begin
            fra = {RW'(row_ff), CW'(col_ff)};
            waddr = {RW'(row_ff), CW'(col_ff)};
            res_data_in = '0;
            res_stat_in = 1'b0;
            unique case (act_ff)
               ACT_LOAD: begin
                  res_stat_in = !cell_ok;
                  if (cell_ok && sel_ok) begin
                     if (sel_ff < GRID_EZ_A) begin
                        fwe = 3'(3'd1 << sel_ff[1:0]);
                     end else begin
                        cwe = 6'(6'd1 << 3'(sel_ff - GRID_EZ_A));
                     end
                  end
               end
               ACT_READ: res_stat_in = !cell_ok;
               ACT_STEP: res_stat_in = !ex_ok;
               default: ;
            endcase
         end
         ST_RDATA: begin
            if (sel_ff < GRID_EZ_A) begin
               res_data_in = fa_q[sel_ff[1:0]];
            end else begin
               res_data_in = c_q[3'(sel_ff - GRID_EZ_A)];
            end
         end
         ST_RD: begin
            if (!upd && phase_ff != PH_FIN) begin
               fra = {src_y, src_x};
            end
            unique case (phase_ff)
               PH_EZ: frb = {y_ff - 1'b1, x_ff};
               PH_HX: frb = {y_ff + 1'b1, x_ff};
               PH_HY: frb = {y_ff, x_ff + 1'b1};
               default: ;
            endcase
         end
         ST_RD2: begin
            frb = {y_ff, x_ff - 1'b1};
            own_in = fa_q;
            nb_in = fb_q;
            unique case (phase_ff)
               PH_HX: begin ca_in = c_q[COEF_HX_A]; cb_in = c_q[COEF_HX_B]; end
               PH_HY: begin ca_in = c_q[COEF_HY_A]; cb_in = c_q[COEF_HY_B]; end
               default: begin ca_in = c_q[COEF_EZ_A]; cb_in = c_q[COEF_EZ_B]; end
            endcase
         end
         ST_CAP: begin
            if (phase_ff == PH_EZ) begin
               d1_in = dif32(own_ff[LANE_HY], fb_q[LANE_HY]);
            end else begin
               d1_in = dif32(nb_ff[LANE_EZ], own_ff[LANE_EZ]);
            end
            d2_in = dif32(own_ff[LANE_HX], nb_ff[LANE_HX]);
            if (phase_ff == PH_SRC) begin
               acc_in = 64'(word_type'(own_ff[LANE_EZ]));
            end else begin
               acc_in = '0;
            end
         end
         ST_MUL: begin
            prod_in = $signed({{32{mul_a[31]}}, mul_a}) * $signed({{32{mul_b[31]}}, mul_b});
            neg_in = mul_neg;
            if (k_ff != 2'd0) acc_in = acc_nxt;
         end
         ST_WR: begin
            fwe = 3'(3'd1 << lane);
            fwd = sat32(acc_nxt);
         end
         ST_MWR: begin
            fwe = 3'(3'd1 << lane);
            if (phase_ff == PH_HX_MR || phase_ff == PH_HY_MC) begin
               fwd = neg32(fa_q[lane]);
            end else begin
               fwd = fa_q[lane];
            end
         end
         ST_FIN: res_data_in = fa_q[LANE_EZ];
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_data_ff;
               rsp_stat_in = res_stat_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_stat_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (fwe[l]) fmem[waddr][l] <= fwd;
      end
      for (int l = 0; l < 6; l++) begin
         if (cwe[l]) cmem[waddr][l] <= word_ff;
      end
      fa_q <= fmem[fra];
      fb_q <= fmem[frb];
      c_q <= cmem[fra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR;
         phase_ff <= PH_EZ;
         clr_ff <= '0;
         k_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff <= 7'd64;
         cols_ff <= 7'd64;
         exr_ff <= 6'd32;
         exc_ff <= 6'd32;
         gain_ff <= '0;
      end else begin
         st_ff <= st_in;
         phase_ff <= phase_in;
         clr_ff <= clr_in;
         k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         exr_ff <= exr_in;
         exc_ff <= exc_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      x_ff <= x_in;
      act_ff <= act_in;
      sel_ff <= sel_in;
      row_ff <= row_in;
      col_ff <= col_in;
      word_ff <= word_in;
      own_ff <= own_in;
      nb_ff <= nb_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
      d1_ff <= d1_in;
      d2_ff <= d2_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      neg_ff <= neg_in;
      res_data_ff <= res_data_in;
      res_stat_ff <= res_stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   `FDTD_ASSERT_NXT(a_accept_exec, clock, reset, req_tvalid && req_tready, st_ff == ST_EXEC)
   `FDTD_ASSERT_IMP(a_mul_count, clock, reset, st_ff == ST_MUL, k_ff <= klast)
   `FDTD_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(st_ff) == ST_RESP)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import fdtd_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   localparam int SEL_EZ = 0, SEL_HX = 1, SEL_HY = 2, SEL_EZ_A = 3, SEL_EZ_B = 4;
   localparam int SEL_HX_A = 5, SEL_HX_B = 6, SEL_HY_A = 7, SEL_HY_B = 8;
   localparam int DIM = 64;
   localparam int FRAC = 24;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;
   bit                     steady = 1'b0;

   fdtd_2d_tm_quadrant_step u_top (.*);

   class field_scoreboard;
      int signed   mem[9][DIM*DIM];
      bit          seen[9][DIM*DIM];
      logic [6:0]  rows_reg, cols_reg;
      logic [5:0]  exc_row, exc_col;
      int signed   gain;
      logic [31:0] want_data[$];
      bit          want_status[$];
      int          errors, n_load, n_read, n_step, n_other;

      function new();
         rows_reg = 64;
         cols_reg = 64;
         exc_row = 32;
         exc_col = 32;
         gain = 0;
      endfunction

      function int dim(logic [6:0] v);
         return (v < 3) ? 3 : (v > DIM) ? DIM : int'(v);
      endfunction

      function bit in_grid(int r, int c);
         return r < dim(rows_reg) && c < dim(cols_reg);
      endfunction

      function int signed sat(longint v);
         return (v > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                (v < -64'sd2147483648) ? 32'sh8000_0000 : int'(v);
      endfunction

      function longint mulq(int signed a, int signed b);
         return (longint'(a) * longint'(b) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      endfunction

      function int signed dif(int signed a, int signed b);
         return sat(longint'(a) - longint'(b));
      endfunction

      function int signed neg(int signed v);
         return sat(-longint'(v));
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_ROWS: rows_reg = v[6:0];
            REG_COLS: cols_reg = v[6:0];
            REG_EXR:  exc_row = v[5:0];
            REG_EXC:  exc_col = v[5:0];
            REG_GAIN: gain = v;
            default: ;
         endcase
      endfunction

      function void advance(int signed sample, bit inject);
         int nr, nc, hy, hx, y, x, p;
         int signed d1, d2;
         nr = dim(rows_reg);
         nc = dim(cols_reg);
         hy = (nr - 1) / 2;
         hx = (nc - 1) / 2;
         for (y = 1; y <= hy; y++)
            for (x = 1; x <= hx; x++) begin
               p = y * DIM + x;
               d1 = dif(mem[SEL_HX][p], mem[SEL_HX][p - DIM]);
               d2 = dif(mem[SEL_HY][p], mem[SEL_HY][p - 1]);
               mem[SEL_EZ][p] = sat(mulq(mem[SEL_EZ_A][p], mem[SEL_EZ][p])
                  + mulq(mem[SEL_EZ_B][p], d2) - mulq(mem[SEL_EZ_B][p], d1));
            end
         if (inject) begin
            p = exc_row * DIM + exc_col;
            mem[SEL_EZ][p] = sat(longint'(mem[SEL_EZ][p]) - mulq(gain, sample));
         end
         for (y = 1; y <= hy; y++)
            for (x = hx + 1; x < nc; x++)
               mem[SEL_EZ][y * DIM + x] = mem[SEL_EZ][y * DIM + nc - 1 - x];
         for (y = hy + 1; y < nr; y++)
            for (x = 1; x < nc; x++)
               mem[SEL_EZ][y * DIM + x] = mem[SEL_EZ][(nr - 1 - y) * DIM + x];
         for (y = 0; y < hy; y++)
            for (x = 0; x <= hx; x++) begin
               p = y * DIM + x;
               d1 = dif(mem[SEL_EZ][p + DIM], mem[SEL_EZ][p]);
               mem[SEL_HX][p] = sat(mulq(mem[SEL_HX_A][p], mem[SEL_HX][p])
                  - mulq(mem[SEL_HX_B][p], d1));
            end
         for (y = 0; y < hy; y++)
            for (x = hx + 1; x < nc; x++)
               mem[SEL_HX][y * DIM + x] = mem[SEL_HX][y * DIM + nc - 1 - x];
         for (y = hy; y + 1 < nr; y++)
            for (x = 1; x < nc; x++)
               mem[SEL_HX][y * DIM + x] = neg(mem[SEL_HX][(nr - 2 - y) * DIM + x]);
         for (y = 0; y <= hy; y++)
            for (x = 0; x < hx; x++) begin
               p = y * DIM + x;
               d1 = dif(mem[SEL_EZ][p + 1], mem[SEL_EZ][p]);
               mem[SEL_HY][p] = sat(mulq(mem[SEL_HY_A][p], mem[SEL_HY][p])
                  + mulq(mem[SEL_HY_B][p], d1));
            end
         for (y = hy + 1; y < nr; y++)
            for (x = 0; x < hx; x++)
               mem[SEL_HY][y * DIM + x] = mem[SEL_HY][(nr - 1 - y) * DIM + x];
         for (y = 0; y < nr; y++)
            for (x = hx; x + 1 < nc; x++)
               mem[SEL_HY][y * DIM + x] = neg(mem[SEL_HY][y * DIM + nc - 2 - x]);
      endfunction

      function void note_request(logic [1:0] act, logic [3:0] sel, logic [5:0] r,
                                 logic [5:0] c, logic [31:0] w);
         logic [31:0] data;
         bit status, ok;
         data = '0;
         status = 1'b0;
         if (act == ACT_LOAD || act == ACT_READ) begin
            if (act == ACT_LOAD) n_load++;
            else n_read++;
            if (!in_grid(r, c)) begin
               status = 1'b1;
            end else if (sel < NUM_GRIDS) begin
               if (act == ACT_LOAD) begin
                  mem[sel][r * DIM + c] = w;
                  seen[sel][r * DIM + c] = 1'b1;
               end else begin
                  data = mem[sel][r * DIM + c];
               end
            end
         end else if (act == ACT_STEP) begin
            n_step++;
            ok = in_grid(exc_row, exc_col);
            advance(w, ok);
            if (ok) data = mem[SEL_EZ][exc_row * DIM + exc_col];
            else status = 1'b1;
         end else begin
            n_other++;
         end
         want_data.push_back(data);
         want_status.push_back(status);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] exp);
         $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, exp);
         errors++;
      endtask

      task check_result(logic [31:0] data, bit status);
         logic [31:0] d;
         bit s;
         if (want_data.size() == 0) begin
            report("unexpected word, data", data, 0);
         end else begin
            d = want_data.pop_front();
            s = want_status.pop_front();
            if (data !== d) report("data", data, d);
            if (status !== s) report("status", status, s);
         end
      endtask

      function int pending();
         return want_data.size();
      endfunction
   endclass

   field_scoreboard sb = new();

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 35);
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[1:0], req_tuser[5:2], req_tdata[5:0], req_tdata[11:6],
                            req_tdata[43:12]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
      end
   end

   task automatic send(input logic [1:0] act, input int sel, input int r, input int c,
                       input logic [31:0] w);
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {sel[3:0], act};
      req_tdata <= {4'b0, w, c[5:0], r[5:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return int'($urandom_range(33554432)) - 16777216;
      endcase
   endfunction

   function automatic logic [31:0] pick_coef();
      if ($urandom_range(19) == 0) return $urandom;
      return int'($urandom_range(16777216)) - ($urandom_range(3) == 0 ? 8388608 : 0);
   endfunction

   function automatic logic [6:0] pick_dim(bit big);
      if (big) return ($urandom_range(1) != 0) ? 7'd127 : 7'd64;
      if ($urandom_range(5) == 0) return 7'($urandom_range(2));
      return 7'($urandom_range(3, 6));
   endfunction

   task automatic random_item(inout int steps_left);
      int k, sel, r, c;
      k = $urandom_range(99);
      r = $urandom_range(63);
      c = $urandom_range(63);
      if ($urandom_range(4) != 0) begin
         r = r % sb.dim(sb.rows_reg);
         c = c % sb.dim(sb.cols_reg);
      end
      if (k >= 60 && k < 90 && steps_left == 0) k = 50;
      if (k < 30) begin
         send(ACT_LOAD, $urandom_range(SEL_HY), r, c, pick_word());
      end else if (k < 45) begin
         send(ACT_LOAD, $urandom_range(SEL_EZ_A, SEL_HY_B), r, c, pick_coef());
      end else if (k < 60) begin
         sel = $urandom_range(SEL_HY_B);
         if (sel >= SEL_EZ_A && sb.in_grid(r, c) && !sb.seen[sel][r * DIM + c]) begin
            r = r % 3;
            c = c % 3;
         end
         send(ACT_READ, sel, r, c, $urandom);
      end else if (k < 90) begin
         steps_left--;
         send(ACT_STEP, $urandom_range(15), $urandom_range(63), $urandom_range(63),
              pick_word());
      end else if (k < 95) begin
         send(2'($urandom_range(1)), $urandom_range(NUM_GRIDS, 15), r, c, $urandom);
      end else begin
         send(ACT_NONE, $urandom_range(15), r, c, $urandom);
      end
   endtask

   initial begin
      int phase, i, r, c, sel, budget;
      logic [6:0] nr, nc;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every coefficient that a step can touch is loaded first; steps run on grids of
      // at most 6 by 6 cells.
      steady = 1'b1;
      for (sel = SEL_EZ_A; sel <= SEL_HY_B; sel++)
         for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
               send(ACT_LOAD, sel, r, c, pick_coef());
      drain();
      steady = 1'b0;

      csr_write(REG_ROWS, 5);
      csr_write(REG_COLS, 6);
      csr_write(REG_EXR, 2);
      csr_write(REG_EXC, 2);
      csr_write(REG_GAIN, 32'h8000_0000);
      send(ACT_LOAD, SEL_EZ, 1, 1, 32'h7FFF_FFFF);
      send(ACT_LOAD, SEL_HX, 0, 1, 32'h8000_0000);
      send(ACT_LOAD, SEL_HY, 1, 0, 32'h8000_0000);
      send(ACT_LOAD, SEL_HY, 4, 5, 32'h0100_0000);
      send(ACT_READ, SEL_EZ, 1, 1, 0);
      send(ACT_READ, SEL_HX, 0, 1, 0);
      send(ACT_READ, SEL_HY, 1, 0, 0);
      send(ACT_READ, SEL_HY_B, 1, 1, 0);
      send(ACT_READ, SEL_EZ, 63, 63, 0);
      send(ACT_LOAD, SEL_EZ, 5, 0, 32'h1234_5678);
      send(ACT_LOAD, SEL_EZ, 0, 6, 32'h1234_5678);
      send(ACT_READ, 15, 1, 1, 0);
      send(ACT_LOAD, 9, 1, 1, 32'hFFFF_FFFF);
      send(ACT_NONE, 15, 63, 63, 32'hFFFF_FFFF);
      send(ACT_STEP, SEL_EZ, 0, 0, 32'h7FFF_FFFF);
      send(ACT_STEP, SEL_EZ, 0, 0, 32'h8000_0000);
      send(ACT_READ, SEL_EZ, 2, 2, 0);
      send(ACT_READ, SEL_HX, 1, 2, 0);
      drain();
      csr_write(REG_EXR, 63);
      csr_write(REG_EXC, 0);
      send(ACT_STEP, SEL_EZ, 0, 0, 32'h0100_0000);
      send(ACT_READ, SEL_EZ, 3, 4, 0);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         nr = pick_dim(phase == 3 || phase == 6);
         nc = pick_dim(phase == 3 || phase == 6);
         csr_write(REG_ROWS, 32'(nr));
         csr_write(REG_COLS, 32'(nc));
         csr_write(REG_EXR, ($urandom_range(4) == 0) ? $urandom_range(63)
                                                      : $urandom_range(sb.dim(nr) - 1));
         csr_write(REG_EXC, ($urandom_range(4) == 0) ? $urandom_range(63)
                                                      : $urandom_range(sb.dim(nc) - 1));
         csr_write(REG_GAIN, pick_word());
         steady = (phase == 5);
         budget = (phase == 3 || phase == 6) ? 0 : 1000;
         for (i = 0; i < 5; i++) random_item(budget);
         drain();
      end

      $display("Covered %0d loads, %0d reads, %0d steps and %0d other words,",
               sb.n_load, sb.n_read, sb.n_step, sb.n_other);
      $display("with steps on grids up to 6 by 6, loads and reads up to 64 by 64.");
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
